/* hw/rtl/wind_vector_averager_core_assert.svh */
// assertion macros shared by the wind vector averager rtl
`ifndef WIND_VECTOR_AVERAGER_CORE_ASSERT_SVH
`define WIND_VECTOR_AVERAGER_CORE_ASSERT_SVH

// implication checked on every rising edge outside reset
`define WVA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define WVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/wva_pkg.sv */
// ---------------------------------------------------------------------------
// wva_pkg
// types, constants and tables shared by the wind vector averager
// ---------------------------------------------------------------------------
package wva_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int CORDIC_STEPS    = 16;
    localparam int STEP_W          = 4;
    localparam int ANG_W           = 22;
    localparam int VEC_W           = 28;
    localparam int SUM_W           = 26;
    localparam int SPD_SUM_W       = 26;
    localparam int CNT_W           = 11;

    localparam logic signed [ANG_W-1:0] QUARTER_UNITS = ANG_W'(900 * 256);
    localparam logic signed [15:0] CORDIC_START = 16'sd19898;
    localparam logic signed [16:0] Q15_MAX = 17'sd32767;
    localparam logic signed [11:0] HALF_TURN = 12'sd1800;

    typedef struct packed {
        logic [15:0] wind_speed;
        logic [11:0] wind_direction;
    } in_word_t;

    typedef struct packed {
        logic [15:0]        mean_speed;
        logic signed [11:0] mean_direction;
        logic [6:0]         records_held;
        logic               overflow;
    } out_word_t;

    // queue entry between classifier and executer
    typedef struct packed {
        logic [15:0] speed;
        logic [11:0] dir;
        logic        drop;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_ACC,
        ST_VEC,
        ST_DIV,
        ST_OUT
    } exec_state_t;

    function automatic logic [ANG_W-1:0] atan_units(input logic [STEP_W-1:0] i);
        logic [ANG_W-1:0] r;
        unique case (i)
            4'd0:  r = 22'd115200;
            4'd1:  r = 22'd68007;
            4'd2:  r = 22'd35933;
            4'd3:  r = 22'd18240;
            4'd4:  r = 22'd9155;
            4'd5:  r = 22'd4582;
            4'd6:  r = 22'd2292;
            4'd7:  r = 22'd1146;
            4'd8:  r = 22'd573;
            4'd9:  r = 22'd286;
            4'd10: r = 22'd143;
            4'd11: r = 22'd72;
            4'd12: r = 22'd36;
            4'd13: r = 22'd18;
            4'd14: r = 22'd9;
            default: r = 22'd4;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/wva_front.sv */
// ---------------------------------------------------------------------------
// wva_front
// accepts observations, marks drops against the record count, two-entry queue
// ---------------------------------------------------------------------------
module wva_front #(
    parameter int MAX_RECORDS = wva_pkg::MAX_RECORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wva_pkg::in_word_t in_data,
    output logic              job_valid,
    input  logic              job_ready,
    output wva_pkg::job_t     job
);

    localparam int CW = $clog2(MAX_RECORDS + 1);

    wva_pkg::job_t q_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          rd_reg, rd_next;
    logic [CW-1:0] held_reg, held_next;
    logic          push, pop, full_now;
    logic [11:0]   dir_mod;

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rd_reg];
    assign full_now  = (held_reg == CW'(MAX_RECORDS));
    assign dir_mod   = (in_data.wind_direction >= 12'd3600) ?
                       in_data.wind_direction - 12'd3600 : in_data.wind_direction;

    always_comb
    begin
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        rd_next   = pop ? ~rd_reg : rd_reg;
        held_next = (push && !full_now) ? held_reg + 1'b1 : held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rd_reg   <= 1'b0;
            held_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            rd_reg   <= rd_next;
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[rd_reg ^ cnt_reg[0]] <= '{speed: in_data.wind_speed, dir: dir_mod,
                                             drop: full_now};
        end
    end

`include "wind_vector_averager_core_assert.svh"
    `WVA_ASSERT_IMPL(a_no_over, clk, rst_n, cnt_reg == 2'd2, !push)
    `WVA_ASSERT_IMPL(a_held_max, clk, rst_n, 1'b1, held_reg <= CW'(MAX_RECORDS))
    `WVA_ASSERT_NEXT(a_pop_cnt, clk, rst_n, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1)

endmodule

/* hw/rtl/wva_back.sv */
// ---------------------------------------------------------------------------
// wva_back
// shared cordic (rotation then vectoring), accumulators and serial divider
// ---------------------------------------------------------------------------
module wva_back #(
    parameter int MAX_RECORDS = wva_pkg::MAX_RECORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  wva_pkg::job_t      job,
    output logic               out_valid,
    input  logic               out_ready,
    output wva_pkg::out_word_t out_data
);

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = wva_pkg::ANG_W;
    localparam int VW = wva_pkg::VEC_W;
    localparam int SW = wva_pkg::SUM_W;
    localparam int DW = wva_pkg::SPD_SUM_W;

    wva_pkg::exec_state_t st_reg, st_next;
    logic [wva_pkg::STEP_W-1:0] step_reg, step_next;
    logic [4:0]               dstep_reg;
    logic signed [VW-1:0]     x_reg, y_reg;
    logic signed [AW-1:0]     z_reg;
    logic                     flip_reg, drop_reg, zero_reg;
    logic [15:0]              spd_reg;
    logic [CW-1:0]            cnt_reg;
    logic [DW-1:0]            ssum_reg;
    logic signed [SW-1:0]     sin_reg, cos_reg;
    logic [DW-1:0]            rem_reg;
    logic [DW-1:0]            quo_reg;
    wva_pkg::out_word_t       res_reg;
    logic                     ov_reg;

    logic signed [VW-1:0] dx, dy;
    logic [AW-1:0]        at;
    logic                 rot_dir;
    logic signed [AW-1:0] t_fold;
    logic                 fold_flip;
    logic signed [VW-1:0] xc, yc;
    logic signed [SW-1:0] sin_n, cos_n;
    logic signed [AW-1:0] zr;
    logic signed [AW-9:0] zs;
    logic signed [11:0]   md;
    logic [DW:0]          trial;

    assign job_ready = (st_reg == wva_pkg::ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign at = wva_pkg::atan_units(step_reg);
    assign rot_dir = (st_reg == wva_pkg::ST_ROT) ? !z_reg[AW-1] : !y_reg[VW-1];

    // fold direction into [-899, 900]
    always_comb
    begin
        logic signed [12:0] t;
        t = $signed({1'b0, job.dir});
        fold_flip = 1'b0;
        priority if (t > 13'sd2700) t = t - 13'sd3600;
        else if (t > 13'sd900)
        begin
            t = t - 13'sd1800;
            fold_flip = 1'b1;
        end
        t_fold = AW'(t) <<< 8;
    end

    always_comb
    begin
        xc = (x_reg > VW'(wva_pkg::Q15_MAX)) ? VW'(wva_pkg::Q15_MAX) :
             (x_reg < -VW'(wva_pkg::Q15_MAX)) ? -VW'(wva_pkg::Q15_MAX) : x_reg;
        yc = (y_reg > VW'(wva_pkg::Q15_MAX)) ? VW'(wva_pkg::Q15_MAX) :
             (y_reg < -VW'(wva_pkg::Q15_MAX)) ? -VW'(wva_pkg::Q15_MAX) : y_reg;
        if (flip_reg)
        begin
            xc = -xc;
            yc = -yc;
        end
        sin_n = sin_reg + SW'(yc);
        cos_n = cos_reg + SW'(xc);
        zr = z_reg + AW'(128);
        zs = zr[AW-1:8];
        md = (zs > (AW-8)'(wva_pkg::HALF_TURN)) ? wva_pkg::HALF_TURN :
             (zs < -(AW-8)'(wva_pkg::HALF_TURN)) ? -wva_pkg::HALF_TURN : 12'(zs);
        trial = {rem_reg, ssum_reg[DW-1-dstep_reg]} - {1'b0, DW'(cnt_reg)};
    end

    always_comb
    begin
        st_next   = st_reg;
        step_next = step_reg;
        unique case (st_reg)
            wva_pkg::ST_IDLE:
                if (job_valid && job_ready)
                begin
                    st_next   = job.drop ? wva_pkg::ST_VEC : wva_pkg::ST_ROT;
                    step_next = '0;
                end
            wva_pkg::ST_ROT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd15) st_next = wva_pkg::ST_ACC;
            end
            wva_pkg::ST_ACC:
                st_next = wva_pkg::ST_VEC;
            wva_pkg::ST_VEC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd15 || zero_reg) st_next = wva_pkg::ST_DIV;
            end
            wva_pkg::ST_DIV:
                if (dstep_reg == 5'(DW-1)) st_next = wva_pkg::ST_OUT;
            wva_pkg::ST_OUT:
                st_next = wva_pkg::ST_IDLE;
            default:
                st_next = wva_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= wva_pkg::ST_IDLE;
            step_reg <= '0;
            cnt_reg  <= '0;
            ssum_reg <= '0;
            sin_reg  <= '0;
            cos_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
            if (st_reg == wva_pkg::ST_OUT) ov_reg <= 1'b1;
            else if (ov_reg && out_ready) ov_reg <= 1'b0;
            if (st_reg == wva_pkg::ST_ACC)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                ssum_reg <= ssum_reg + DW'(spd_reg);
                sin_reg  <= sin_n;
                cos_reg  <= cos_n;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            wva_pkg::ST_IDLE:
            begin
                spd_reg  <= job.speed;
                drop_reg <= job.drop;
                flip_reg <= fold_flip;
                // drops go straight to vectoring on the held sums
                if (job.drop)
                begin
                    zero_reg <= (sin_reg == '0) && (cos_reg == '0);
                    if (cos_reg < 0)
                    begin
                        if (sin_reg >= 0)
                        begin
                            x_reg <= VW'(sin_reg);
                            y_reg <= -VW'(cos_reg);
                            z_reg <= wva_pkg::QUARTER_UNITS;
                        end
                        else
                        begin
                            x_reg <= -VW'(sin_reg);
                            y_reg <= VW'(cos_reg);
                            z_reg <= -wva_pkg::QUARTER_UNITS;
                        end
                    end
                    else
                    begin
                        x_reg <= VW'(cos_reg);
                        y_reg <= VW'(sin_reg);
                        z_reg <= '0;
                    end
                end
                else
                begin
                    x_reg <= VW'(wva_pkg::CORDIC_START);
                    y_reg <= '0;
                    z_reg <= t_fold;
                end
            end
            wva_pkg::ST_ROT, wva_pkg::ST_VEC:
            begin
                if (rot_dir)
                begin
                    x_reg <= (st_reg == wva_pkg::ST_ROT) ? x_reg - dx : x_reg + dx;
                    y_reg <= (st_reg == wva_pkg::ST_ROT) ? y_reg + dy : y_reg - dy;
                    z_reg <= (st_reg == wva_pkg::ST_ROT) ? z_reg - $signed(at)
                                                         : z_reg + $signed(at);
                end
                else
                begin
                    x_reg <= (st_reg == wva_pkg::ST_ROT) ? x_reg + dx : x_reg - dx;
                    y_reg <= (st_reg == wva_pkg::ST_ROT) ? y_reg - dy : y_reg + dy;
                    z_reg <= (st_reg == wva_pkg::ST_ROT) ? z_reg + $signed(at)
                                                         : z_reg - $signed(at);
                end
                rem_reg   <= '0;
                dstep_reg <= '0;
            end
            wva_pkg::ST_ACC:
            begin
                zero_reg <= (sin_n == '0) && (cos_n == '0);
                if (cos_n < 0)
                begin
                    if (sin_n >= 0)
                    begin
                        x_reg <= VW'(sin_n);
                        y_reg <= -VW'(cos_n);
                        z_reg <= wva_pkg::QUARTER_UNITS;
                    end
                    else
                    begin
                        x_reg <= -VW'(sin_n);
                        y_reg <= VW'(cos_n);
                        z_reg <= -wva_pkg::QUARTER_UNITS;
                    end
                end
                else
                begin
                    x_reg <= VW'(cos_n);
                    y_reg <= VW'(sin_n);
                    z_reg <= '0;
                end
            end
            wva_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (!trial[DW])
                begin
                    rem_reg <= trial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DW-2:0], ssum_reg[DW-1-dstep_reg]};
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                dstep_reg <= dstep_reg + 1'b1;
            end
            wva_pkg::ST_OUT:
            begin
                res_reg.mean_speed     <= (cnt_reg == '0) ? 16'd0 : quo_reg[15:0];
                res_reg.mean_direction <= zero_reg ? 12'sd0 : md;
                res_reg.records_held   <= 7'(cnt_reg);
                res_reg.overflow       <= drop_reg;
            end
            default: ;
        endcase
    end

`include "wind_vector_averager_core_assert.svh"
    `WVA_ASSERT_IMPL(a_ready_idle, clk, rst_n, job_ready, st_reg == wva_pkg::ST_IDLE)
    `WVA_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= CW'(MAX_RECORDS))
    `WVA_ASSERT_NEXT(a_out_set, clk, rst_n, st_reg == wva_pkg::ST_OUT, out_valid)

endmodule

/* hw/rtl/wind_vector_averager_core.sv */
// path: a kept observation goes through the front queue, rotation, accumulation,
// vectoring, division and the output state; a dropped one skips rotation and
// accumulation, and vectoring stops early when both sums are zero
// the back end takes one observation at a time, busy through 16 rotation and 16
// vectoring cordic steps, the 26-step divider and the result register, which holds it until read
// reset: asynchronous, clears record count and all sums, no clearing pass
// ---------------------------------------------------------------------------
// wind_vector_averager_core
// mean wind speed and circular mean direction over held observations
// ---------------------------------------------------------------------------
module wind_vector_averager_core #(
    parameter int MAX_RECORDS = wva_pkg::MAX_RECORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wva_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wva_pkg::out_word_t out_data
);

    logic          job_valid, job_ready;
    wva_pkg::job_t job;

    wva_front #(.MAX_RECORDS(MAX_RECORDS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_data,
        .job_valid, .job_ready, .job
    );

    wva_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
        .clk, .rst_n, .job_valid, .job_ready, .job,
        .out_valid, .out_ready, .out_data
    );

endmodule
